@@ hdl/rmq_pkg.sv @@
package rmq_pkg;

  localparam int DataWidth = 16;
  localparam int FracBits  = 14;

  // root argument: up to 3*2^15 + 2^14, shifted by FracBits
  localparam int ArgW  = DataWidth + 3;
  localparam int RadW  = ArgW + FracBits;          // 33
  localparam int RadWE = RadW + (RadW % 2);        // even
  localparam int RootW = RadWE / 2;                // 17
  localparam int DiffW = DataWidth + 1;            // signed numerator
  localparam int MagW  = DataWidth;                // |d| <= 2^16 needs 17 bits, one more than MagW
  localparam int NumW  = DiffW + FracBits + 1;     // (mag<<F)+s
  localparam int DenW  = RootW + 1;
  localparam int QW    = NumW;

  localparam logic [1:0] PathTrace = 2'd0;
  localparam logic [1:0] PathX     = 2'd1;
  localparam logic [1:0] PathY     = 2'd2;
  localparam logic [1:0] PathZ     = 2'd3;

  typedef struct packed {
    logic signed [DataWidth-1:0] m11;
    logic signed [DataWidth-1:0] m12;
    logic signed [DataWidth-1:0] m13;
    logic signed [DataWidth-1:0] m21;
    logic signed [DataWidth-1:0] m22;
    logic signed [DataWidth-1:0] m23;
    logic signed [DataWidth-1:0] m31;
    logic signed [DataWidth-1:0] m32;
    logic signed [DataWidth-1:0] m33;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] quat_w;
    logic signed [DataWidth-1:0] quat_x;
    logic signed [DataWidth-1:0] quat_y;
    logic signed [DataWidth-1:0] quat_z;
    logic [1:0]                  path_taken;
  } out_word_t;

  // front end result: root argument, three signed numerators in w,x,y,z slots
  typedef struct packed {
    logic                     vld;
    logic [RadWE-1:0]         rad;
    logic [1:0]               path;
    logic signed [DiffW:0]    nw;
    logic signed [DiffW:0]    nx;
    logic signed [DiffW:0]    ny;
    logic signed [DiffW:0]    nz;
  } front_t;

  // root stage to divider
  typedef struct packed {
    logic                     vld;
    logic [RootW-1:0]         s;
    logic [1:0]               path;
    logic signed [DiffW:0]    nw;
    logic signed [DiffW:0]    nx;
    logic signed [DiffW:0]    ny;
    logic signed [DiffW:0]    nz;
  } root_t;

endpackage

@@ hdl/rotation_matrix_to_quaternion_core.sv @@
// Rotation matrix to quaternion converter (Shepperd's method), Q2.14.
// Input channel: a matrix word is taken on in_word at each rising edge
// where start is high and busy is low. busy is tied low: a new word may
// enter on every cycle.
// Result channel: out_valid pulses for one cycle with out_word holding
// quat_w/x/y/z (saturated) and path_taken. The receiver cannot stall and
// none is needed: results leave in order, one per accepted word.
// Pipeline: trace/axis select register, 17 square root stages (one bit
// a stage), 32 four-lane divider stages (one quotient bit a stage) and
// the output register. Throughput: one word per cycle, set by the fully
// pipelined root and divider.
// Reset (rst_n low, synchronous) clears every valid bit; words in flight
// are dropped and no result follows them.
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  front_t f;
  root_t  r;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk(clk), .rst_n(rst_n), .vld_in(start), .din(in_word), .dout(f)
  );

  rmq_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .din(f), .dout(r)
  );

  rmq_div u_div (
    .clk(clk), .rst_n(rst_n), .din(r), .vld_out(out_valid), .dout(out_word)
  );

endmodule

@@ hdl/rmq_front.sv @@
module rmq_front
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     vld_in,
  input  in_word_t din,
  output front_t   dout
);

  front_t dout_r, dout_nxt;

  logic signed [ArgW-1:0] tr, a, one;
  logic signed [ArgW-1:0] d11, d22, d33;
  logic signed [DiffW:0]  sub_a, sub_b, sub_c, add_a, add_b, add_c;
  logic [1:0]             axis;

  always_comb begin
    one = ArgW'(1) <<< FracBits;
    d11 = ArgW'(din.m11);
    d22 = ArgW'(din.m22);
    d33 = ArgW'(din.m33);
    tr  = d11 + d22 + d33;
    // off-diagonal sums and differences
    sub_a = (DiffW+1)'(din.m23) - (DiffW+1)'(din.m32);
    sub_b = (DiffW+1)'(din.m31) - (DiffW+1)'(din.m13);
    sub_c = (DiffW+1)'(din.m12) - (DiffW+1)'(din.m21);
    add_a = (DiffW+1)'(din.m23) + (DiffW+1)'(din.m32);
    add_b = (DiffW+1)'(din.m31) + (DiffW+1)'(din.m13);
    add_c = (DiffW+1)'(din.m12) + (DiffW+1)'(din.m21);
    // largest diagonal, ties keep lower axis
    axis = PathX;
    if (din.m22 > din.m11) axis = PathY;
    if (axis == PathX) begin
      if (din.m33 > din.m11) axis = PathZ;
    end else begin
      if (din.m33 > din.m22) axis = PathZ;
    end
    dout_nxt.vld = vld_in;
    if (tr > 0) begin
      a = tr + one;
      dout_nxt.path = PathTrace;
      dout_nxt.nw = '0;
      dout_nxt.nx = sub_a;
      dout_nxt.ny = sub_b;
      dout_nxt.nz = sub_c;
    end else begin
      dout_nxt.path = axis;
      case (axis)
        PathX: begin
          a = d11 - d22 - d33 + one;
          dout_nxt.nw = sub_a; dout_nxt.nx = '0;
          dout_nxt.ny = add_c; dout_nxt.nz = add_b;
        end
        PathY: begin
          a = d22 - d33 - d11 + one;
          dout_nxt.nw = sub_b; dout_nxt.nx = add_c;
          dout_nxt.ny = '0;    dout_nxt.nz = add_a;
        end
        default: begin
          a = d33 - d11 - d22 + one;
          dout_nxt.nw = sub_c; dout_nxt.nx = add_b;
          dout_nxt.ny = add_a; dout_nxt.nz = '0;
        end
      endcase
    end
    // clamp negative argument
    if (a <= 0) dout_nxt.rad = '0;
    else        dout_nxt.rad = RadWE'({a[ArgW-2:0], {FracBits{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dout_r.vld <= 1'b0;
    else        dout_r.vld <= dout_nxt.vld;
    dout_r.rad  <= dout_nxt.rad;
    dout_r.path <= dout_nxt.path;
    dout_r.nw   <= dout_nxt.nw;
    dout_r.nx   <= dout_nxt.nx;
    dout_r.ny   <= dout_nxt.ny;
    dout_r.nz   <= dout_nxt.nz;
  end

  assign dout = dout_r;

endmodule

@@ hdl/rmq_sqrt.sv @@
module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  front_t din,
  output root_t  dout
);

  // one result bit per stage, restoring square root
  localparam int Steps = RootW;
  localparam int RemW  = RootW + 2;

  logic                      vld_r  [Steps+1];
  logic [RadWE-1:0]          rad_r  [Steps+1];
  logic [RemW-1:0]           rem_r  [Steps+1];
  logic [RootW-1:0]          root_r [Steps+1];
  logic [1:0]                path_r [Steps+1];
  logic signed [DiffW:0]     nw_r [Steps+1];
  logic signed [DiffW:0]     nx_r [Steps+1];
  logic signed [DiffW:0]     ny_r [Steps+1];
  logic signed [DiffW:0]     nz_r [Steps+1];

  always_comb begin
    vld_r[0]  = din.vld;
    rad_r[0]  = din.rad;
    rem_r[0]  = '0;
    root_r[0] = '0;
    path_r[0] = din.path;
    nw_r[0] = din.nw; nx_r[0] = din.nx; ny_r[0] = din.ny; nz_r[0] = din.nz;
  end

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    logic [RemW-1:0] rem_nxt, trial;
    always_comb begin
      rem_nxt = {rem_r[g][RemW-3:0], rad_r[g][RadWE-1 -: 2]};
      trial   = RemW'({root_r[g], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else        vld_r[g+1] <= vld_r[g];
      rad_r[g+1] <= rad_r[g] << 2;
      if (rem_nxt >= trial) begin
        rem_r[g+1]  <= rem_nxt - trial;
        root_r[g+1] <= {root_r[g][RootW-2:0], 1'b1};
      end else begin
        rem_r[g+1]  <= rem_nxt;
        root_r[g+1] <= {root_r[g][RootW-2:0], 1'b0};
      end
      path_r[g+1] <= path_r[g];
      nw_r[g+1] <= nw_r[g]; nx_r[g+1] <= nx_r[g];
      ny_r[g+1] <= ny_r[g]; nz_r[g+1] <= nz_r[g];
    end
  end

  always_comb begin
    dout.vld  = vld_r[Steps];
    dout.s    = root_r[Steps];
    dout.path = path_r[Steps];
    dout.nw = nw_r[Steps]; dout.nx = nx_r[Steps];
    dout.ny = ny_r[Steps]; dout.nz = nz_r[Steps];
  end

endmodule

@@ hdl/rmq_div.sv @@
module rmq_div
  import rmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  root_t     din,
  output logic      vld_out,
  output out_word_t dout
);

  // four lanes of restoring division, one quotient bit per stage
  localparam int Steps = QW;
  localparam logic [QW-1:0] PosMax = QW'((1 << (DataWidth-1)) - 1);
  localparam logic [QW-1:0] NegMax = QW'(1 << (DataWidth-1));

  logic                 vld_r  [Steps+1];
  logic [RootW-1:0]     s_r    [Steps+1];
  logic [1:0]           path_r [Steps+1];
  logic [3:0]           neg_r  [Steps+1];
  logic [NumW-1:0]      num_r  [Steps+1][4];
  logic [DenW:0]        rem_r  [Steps+1][4];
  logic [QW-1:0]        quo_r  [Steps+1][4];

  logic signed [DiffW:0] n_in [4];
  logic [DiffW:0]        mag  [4];

  always_comb begin
    n_in[0] = din.nw; n_in[1] = din.nx; n_in[2] = din.ny; n_in[3] = din.nz;
    vld_r[0]  = din.vld;
    s_r[0]    = din.s;
    path_r[0] = din.path;
    for (int l = 0; l < 4; l++) begin
      neg_r[0][l] = n_in[l][DiffW];
      mag[l] = n_in[l][DiffW] ? (DiffW+1)'(0) - n_in[l] : n_in[l];
      num_r[0][l] = (NumW'(mag[l]) << FracBits) + NumW'(din.s);
      rem_r[0][l] = '0;
      quo_r[0][l] = '0;
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    logic [DenW:0] den;
    logic [DenW:0] sh [4];
    always_comb begin
      den = (DenW+1)'({s_r[g], 1'b0});
      for (int l = 0; l < 4; l++) sh[l] = {rem_r[g][l][DenW-1:0], num_r[g][l][NumW-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else        vld_r[g+1] <= vld_r[g];
      s_r[g+1]    <= s_r[g];
      path_r[g+1] <= path_r[g];
      neg_r[g+1]  <= neg_r[g];
      for (int l = 0; l < 4; l++) begin
        num_r[g+1][l] <= num_r[g][l] << 1;
        if (sh[l] >= den) begin
          rem_r[g+1][l] <= sh[l] - den;
          quo_r[g+1][l] <= {quo_r[g][l][QW-2:0], 1'b1};
        end else begin
          rem_r[g+1][l] <= sh[l];
          quo_r[g+1][l] <= {quo_r[g][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturation, half root in the chosen lane
  logic [DataWidth-1:0] res [4];
  logic [RootW-1:0]     half;
  logic [QW-1:0]        q;
  logic [1:0]           p;
  always_comb begin
    p    = path_r[Steps];
    half = RootW'((RootW+1)'(s_r[Steps]) + 1'b1 >> 1);
    for (int l = 0; l < 4; l++) begin
      q = quo_r[Steps][l];
      if (s_r[Steps] == '0) res[l] = '0;
      else if (neg_r[Steps][l]) begin
        if (q >= NegMax) res[l] = DataWidth'(NegMax);
        else             res[l] = DataWidth'(QW'(0) - q);
      end else begin
        if (q > PosMax)  res[l] = DataWidth'(PosMax);
        else             res[l] = DataWidth'(q);
      end
      if (l == 0 && p == PathTrace || l != 0 && p == 2'(l)) begin
        if (QW'(half) > PosMax) res[l] = DataWidth'(PosMax);
        else                    res[l] = DataWidth'(half);
      end
    end
  end

  out_word_t dout_r;
  logic      vld_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_out_r <= 1'b0;
    else        vld_out_r <= vld_r[Steps];
    dout_r.quat_w     <= res[0];
    dout_r.quat_x     <= res[1];
    dout_r.quat_y     <= res[2];
    dout_r.quat_z     <= res[3];
    dout_r.path_taken <= p;
  end

  assign vld_out = vld_out_r;
  assign dout    = dout_r;

endmodule

@@ tb/sv/tb_rotation_matrix_to_quaternion_core.sv @@
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  localparam int Latency = 51;
  localparam longint One = 64'sd1 << FracBits;
  localparam longint SMax = (64'sd1 <<< (DataWidth - 1)) - 1;
  localparam longint SMin = -(64'sd1 <<< (DataWidth - 1));

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  in_word_t  matrix_q[$];
  out_word_t quat_q[$];
  int        gap_left;
  bit        failed;
  bit        stim_done;

  rotation_matrix_to_quaternion_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root_of(longint a);
    if (a <= 0) return 0;
    return int_sqrt(longint'(a) << FracBits);
  endfunction

  // d / (2s), rounded half away from zero, saturated
  function automatic longint scaled_quot(longint d, longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    if (s == 0) return 0;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = ((mag << FracBits) + s) / (s << 1);
    if (d < 0) return (q > longint'(-SMin)) ? SMin : -longint'(q);
    return (q > SMax) ? SMax : longint'(q);
  endfunction

  function automatic longint half_root(longint unsigned s);
    longint unsigned h;
    h = (s + 1) >> 1;
    return (h > SMax) ? SMax : longint'(h);
  endfunction

  // expected quaternion for one matrix
  function automatic out_word_t quat_of_matrix(in_word_t w);
    longint m[3][3];
    longint q[4]; // x y z w
    longint tr;
    longint unsigned s;
    int i, j, k;
    out_word_t r;
    m[0][0] = w.m11; m[0][1] = w.m12; m[0][2] = w.m13;
    m[1][0] = w.m21; m[1][1] = w.m22; m[1][2] = w.m23;
    m[2][0] = w.m31; m[2][1] = w.m32; m[2][2] = w.m33;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = root_of(tr + One);
      q[3] = half_root(s);
      q[0] = scaled_quot(m[1][2] - m[2][1], s);
      q[1] = scaled_quot(m[2][0] - m[0][2], s);
      q[2] = scaled_quot(m[0][1] - m[1][0], s);
      r.path_taken = PathTrace;
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = root_of(m[i][i] - (m[j][j] + m[k][k]) + One);
      q[i] = half_root(s);
      q[3] = scaled_quot(m[j][k] - m[k][j], s);
      q[j] = scaled_quot(m[i][j] + m[j][i], s);
      q[k] = scaled_quot(m[i][k] + m[k][i], s);
      case (i)
        0: begin r.path_taken = PathX; end
        1: begin r.path_taken = PathY; end
        default: begin r.path_taken = PathZ; end
      endcase
    end
    r.quat_w = q[3][DataWidth-1:0];
    r.quat_x = q[0][DataWidth-1:0];
    r.quat_y = q[1][DataWidth-1:0];
    r.quat_z = q[2][DataWidth-1:0];
    return r;
  endfunction

  function automatic logic [DataWidth-1:0] rnd_entry(int mode);
    case (mode)
      0: return DataWidth'($urandom);
      1: return DataWidth'(int'($urandom_range(0, 32767)) - 16384);  // roughly in [-1,1]
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic push_diag(int a, int b, int c, int mode);
    in_word_t w;
    w = {9{rnd_entry(mode)}};
    w.m12 = rnd_entry(mode); w.m13 = rnd_entry(mode); w.m21 = rnd_entry(mode);
    w.m23 = rnd_entry(mode); w.m31 = rnd_entry(mode); w.m32 = rnd_entry(mode);
    w.m11 = DataWidth'(a); w.m22 = DataWidth'(b); w.m33 = DataWidth'(c);
    matrix_q.push_back(w);
  endtask

  // stimulus
  initial begin
    in_word_t w;
    int mode;
    push_diag(16384, 16384, 16384, 1);      // identity-like, trace path
    push_diag(16384, -16384, -16384, 1);    // x axis
    push_diag(-16384, 16384, -16384, 1);    // y axis
    push_diag(-16384, -16384, 16384, 1);    // z axis
    push_diag(0, 0, 0, 1);                  // zero trace, tie keeps x
    push_diag(-100, -100, -100, 1);         // tie on diagonal
    push_diag(-32768, -32768, -32768, 2);   // most negative diagonal, tie keeps x
    push_diag(-16384, -16384, -16384, 1);   // tie on diagonal at -1, positive root argument
    push_diag(-8192, 8192, 8192, 1);        // positive trace, trace path despite y/z tie
    push_diag(32767, 32767, 32767, 2);      // trace max
    push_diag(32767, -32768, -32768, 2);    // axis max argument
    push_diag(1, 0, 0, 2);                  // tiny positive trace
    matrix_q.push_back('0);
    matrix_q.push_back('1);
    w = {9{16'h7fff}};
    matrix_q.push_back(w);
    w = {9{16'h8000}};
    matrix_q.push_back(w);
    for (int n = 0; n < 1200; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        matrix_q.push_back(w);
      end else if (mode < 3) begin
        push_diag(rnd_entry(2), rnd_entry(2), rnd_entry(2), 2);
      end else begin
        push_diag(rnd_entry(1), rnd_entry(1), rnd_entry(1), 1);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
    end else if (start && !busy) begin
      void'(matrix_q.pop_front());
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
      if (matrix_q.size() != 0 && gap_left == 0) begin
        in_word <= matrix_q[0];
      end else begin
        start <= 1'b0;
        // the cycle with start low counts as the first idle one
        if (gap_left > 0) gap_left--;
        if (matrix_q.size() == 0) stim_done = 1'b1;
      end
    end else if (!start && matrix_q.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        in_word <= matrix_q[0];
        start <= 1'b1;
      end
    end
  end

  // expectation on acceptance, check on result
  always @(posedge clk) begin
    out_word_t exp_q;
    if (rst_n && start && !busy) quat_q.push_back(quat_of_matrix(in_word));
    if (rst_n && out_valid) begin
      if (quat_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_word);
        failed = 1'b1;
      end else begin
        exp_q = quat_q.pop_front();
        if (exp_q !== out_word) begin
          $display("%0t mismatch w/x/y/z/path expected %h %h %h %h %0d actual %h %h %h %h %0d",
                   $time, exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                   exp_q.path_taken, out_word.quat_w, out_word.quat_x,
                   out_word.quat_y, out_word.quat_z, out_word.path_taken);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done && quat_q.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
